>>> rtl/sdt_pkg.sv
// sdt_pkg: shared types, command and status codes and the date key function
// for the sorted date table. No dependencies.
`default_nettype none
package sdt_pkg;

  localparam int SDT_TABLE_DEPTH = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DATE_W  = MONTH_W + DAY_W;
  localparam int KEY_W   = 9;   // 30*15+31 = 481 fits

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DUMP_ENT  = 3'd5;

  typedef logic [DATE_W-1:0] date_t;   // {month, day}
  typedef logic [KEY_W-1:0]  key_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic  insert;
    logic  rotate;
    date_t new_date;
    key_t  new_key;
  } cell_ctl_t;

  // link from one cell to the next one down the chain
  typedef struct packed {
    logic  valid;
    logic  gt;
    date_t date;
  } cell_link_t;

  // key = 30*month + day, as (m<<5) - (m<<1) + d
  function automatic key_t date_key(date_t d);
    key_t m32;
    key_t m2;
    key_t dd;
    m32 = {d[DATE_W-1 -: MONTH_W], 5'b0};
    m2  = {4'b0, d[DATE_W-1 -: MONTH_W], 1'b0};
    dd  = {4'b0, d[DAY_W-1:0]};
    return m32 - m2 + dd;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sorted_date_table.sv
// sorted_date_table: insert/query one request per cycle unless stalled, result registered.
// Dump of N entries: first entry loaded in DUMP state after acceptance, then one per cycle
// unless stalled (the chain rotates one slot per entry), input blocked until the dump ends.
// Output is a single register; a stalled result holds the block.
// Reset (rst_n low, synchronous) clears slot valid bits, entry count and FSM;
// slot contents are not cleared, there is no clearing pass.
`default_nettype none
module sorted_date_table
  import sdt_pkg::*;
#(
  parameter int TABLE_DEPTH = SDT_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [MONTH_W-1:0] in_month,
  input  wire logic [DAY_W-1:0]   in_day,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [MONTH_W-1:0]      out_entry_month,
  output logic [DAY_W-1:0]        out_entry_day,
  output logic                    out_entry_valid,
  output logic                    out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // ---- chain of cells; cell 0 holds the largest key ----
  cell_ctl_t  ctl;
  cell_link_t link_out [TABLE_DEPTH];
  cell_link_t link_in  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] tail_vec;
  date_t      tail_date;
  logic       dup;
  logic       full;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        // head sees a virtual valid cell above that always keeps its entry;
        // during a dump it receives the tail, closing the ring
        assign link_in[gi].valid = 1'b1;
        assign link_in[gi].gt    = 1'b1;
        assign link_in[gi].date  = tail_date;
      end else begin : g_body
        assign link_in[gi] = link_out[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_end
        assign tail_vec[gi] = link_out[gi].valid;
      end else begin : g_mid
        assign tail_vec[gi] = link_out[gi].valid & ~link_out[gi+1].valid;
      end
      sdt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .link_in  (link_in[gi]),
        .link_out (link_out[gi]),
        .match    (match_vec[gi])
      );
    end
  endgenerate

  // tail is one-hot once any cell is occupied (occupied cells are contiguous from the head)
  always_comb begin
    tail_date = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tail_date = tail_date | ({DATE_W{tail_vec[i]}} & link_out[i].date);
    end
  end

  assign dup  = |match_vec;
  assign full = link_out[TABLE_DEPTH-1].valid;

  // ---- control ----
  fsm_t         state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          out_free;
  logic          in_fire;
  logic          load_out;
  logic [2:0]    status_nxt;
  date_t         entry_nxt;
  logic          entry_valid_nxt;
  logic          last_nxt;
  date_t         in_date;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  date_t              out_entry_r;
  logic               out_entry_valid_r;
  logic               out_last_r;

  assign in_date  = {in_month, in_day};
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire && in_cmd == CMD_DUMP && count_r != '0) begin
          state_nxt = FSM_DUMP;
        end
      end
      FSM_DUMP: begin
        if (out_free && rem_r == CW'(1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    ctl.insert      = 1'b0;
    ctl.rotate      = 1'b0;
    ctl.new_date    = in_date;
    ctl.new_key     = date_key(in_date);
    count_nxt       = count_r;
    rem_nxt         = rem_r;
    load_out        = 1'b0;
    status_nxt      = ST_DUMP_ENT;
    entry_nxt       = '0;
    entry_valid_nxt = 1'b0;
    last_nxt        = 1'b1;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_INSERT: begin
              load_out = 1'b1;
              if (dup) begin
                status_nxt = ST_DUPLICATE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_INSERTED;
                ctl.insert = 1'b1;
                count_nxt  = count_r + CW'(1);
              end
            end
            CMD_QUERY: begin
              load_out   = 1'b1;
              status_nxt = dup ? ST_FOUND : ST_NOT_FOUND;
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                load_out = 1'b1;   // empty dump
              end else begin
                rem_nxt = count_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          load_out        = 1'b1;
          entry_nxt       = tail_date;
          entry_valid_nxt = 1'b1;
          last_nxt        = (rem_r == CW'(1));
          ctl.rotate      = 1'b1;
          rem_nxt         = rem_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r      <= status_nxt;
      out_entry_r       <= entry_nxt;
      out_entry_valid_r <= entry_valid_nxt;
      out_last_r        <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_month = out_entry_r[DATE_W-1 -: MONTH_W];
  assign out_entry_day   = out_entry_r[DAY_W-1:0];
  assign out_entry_valid = out_entry_valid_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

>>> rtl/sdt_cell.sv
// sdt_cell: one slot of the sorted date table chain.
// Depends on sdt_pkg.
`default_nettype none
module sdt_cell
  import sdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cell_ctl_t       ctl,
  input  cell_link_t      link_in,   // from the cell above (larger keys)
  output cell_link_t      link_out,
  output logic            match
);

  date_t date_r, date_nxt;
  logic  valid_r, valid_nxt;
  logic  gt;

  assign gt    = valid_r && (date_key(date_r) > ctl.new_key);
  assign match = valid_r && (date_r == ctl.new_date);

  assign link_out.valid = valid_r;
  assign link_out.gt    = gt;
  assign link_out.date  = date_r;

  always_comb begin
    date_nxt  = date_r;
    valid_nxt = valid_r;
    if (ctl.insert) begin
      if (!gt) begin
        // new date lands here if the cell above keeps its entry, else shift down
        date_nxt  = link_in.gt ? ctl.new_date : link_in.date;
        valid_nxt = valid_r | link_in.valid;
      end
    end else if (ctl.rotate) begin
      if (valid_r) begin
        date_nxt = link_in.date;
      end
    end
  end

  always_ff @(posedge clk) begin
    date_r <= date_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sdt_checker.sv
// sdt_checker: port-level checks on sorted_date_table, bound to the top level.
// Depends on sdt_pkg.
`default_nettype none
module sdt_checker
  import sdt_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         out_status,
  input wire logic [MONTH_W-1:0] out_entry_month,
  input wire logic [DAY_W-1:0]   out_entry_day,
  input wire logic               out_entry_valid,
  input wire logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("non-entry result not marked last");

  a_entry_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_status == ST_DUMP_ENT)
    else $error("entry result with wrong status");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_entry_month == '0 && out_entry_day == '0)
    else $error("entry fields set on non-entry result");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_date_table sdt_checker u_sdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_entry_month (out_entry_month),
  .out_entry_day   (out_entry_day),
  .out_entry_valid (out_entry_valid),
  .out_last        (out_last)
);
`default_nettype wire
